### sv/tre_pkg.sv
`default_nettype none

package tre_pkg;

   // default history depth
   localparam int HISTORY_DEPTH_DEF = 128;

   // csr register indexes
   localparam logic [1:0] CSR_WIN_LOW    = 2'd0;
   localparam logic [1:0] CSR_WIN_HIGH   = 2'd1;
   localparam logic [1:0] CSR_FORGET     = 2'd2;
   localparam logic [1:0] CSR_INIT_RATIO = 2'd3;

   // request types
   localparam logic [1:0] REQ_CMD = 2'd0;
   localparam logic [1:0] REQ_EST = 2'd1;
   localparam logic [1:0] REQ_RST = 2'd2;

   // reset values
   localparam logic [19:0] WIN_LOW_RST    = 20'd35000;
   localparam logic [19:0] WIN_HIGH_RST   = 20'd45000;
   localparam logic [16:0] FORGET_RST     = 17'd65405;
   localparam logic [30:0] INIT_RATIO_RST = 31'd2143027;
   localparam logic [63:0] COV_INIT       = 64'd1099511627776000000;
   localparam logic [30:0] RATIO_MAX      = 31'h7FFF_FFFF;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_THR_DIV,
      OP_THR_DONE,
      OP_POP,
      OP_CONSUME,
      OP_MUL_TT,
      OP_MUL_TP,
      OP_CAP_D,
      OP_MUL_PT,
      OP_DIV_K,
      OP_CAP_K,
      OP_MUL_TR,
      OP_CAP_E,
      OP_MUL_KE,
      OP_CAP_RATIO,
      OP_DIV_P,
      OP_CAP_P,
      OP_RESET_MAP
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_THR_DIV,
      S_THR_W,
      S_THR_DONE,
      S_RMAP,
      S_POP_RD,
      S_POP_CHK,
      S_TT,
      S_TT_W,
      S_TP,
      S_TP_W,
      S_PT,
      S_PT_W,
      S_DK,
      S_DK_W,
      S_TR,
      S_TR_W,
      S_KE,
      S_KE_W,
      S_DP,
      S_DP_W,
      S_RESULT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic fill_zero;
      logic too_old;
      logic too_young;
      logic ratio_zero;
   } dp_status_type;

endpackage

`default_nettype wire

### sv/tre_mul.sv
`default_nettype none

// 64x64 multiply, one 32x32 partial product per cycle
module tre_mul import tre_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [63:0]   a,
   input  wire logic [63:0]   b,
   output logic               done,
   output logic [127:0]       prod
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [1:0]   step_ff, step_in;
   logic         run_ff, run_in, pp_vld_ff, pp_vld_in, fin_ff, fin_in, done_ff, done_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  ah, bh;

   always_comb begin
      ah = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      bh = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      a_in = a_ff;
      b_in = b_ff;
      step_in = step_ff;
      run_in = run_ff;
      pp_in = ah * bh;
      sh_in = 2'(step_ff[1]) + 2'(step_ff[0]);
      pp_vld_in = run_ff;
      fin_in = run_ff && (step_ff == 2'd3);
      done_in = fin_ff;
      acc_in = acc_ff;
      if (pp_vld_ff) begin
         acc_in = acc_ff + ({64'b0, pp_ff} << {sh_ff, 5'b0});
      end
      if (run_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in = 1'b0;
         end
      end
      if (start) begin
         a_in = a;
         b_in = b;
         step_in = 2'd0;
         run_in = 1'b1;
         acc_in = '0;
         pp_vld_in = 1'b0;
         fin_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pp_vld_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         run_ff <= run_in;
         pp_vld_ff <= pp_vld_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      pp_ff <= pp_in;
      sh_ff <= sh_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

### sv/tre_div.sv
`default_nettype none

// 128 by 64 restoring division, one quotient bit per cycle, saturating
module tre_div import tre_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] x_hi,
   input  wire logic [63:0] x_lo,
   input  wire logic [63:0] d,
   output logic             done,
   output logic [63:0]      q
);

   logic [63:0] r_ff, r_in, xl_ff, xl_in, q_ff, q_in, d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [63:0] rs;
   logic        carry;

   always_comb begin
      carry = r_ff[63];
      rs = {r_ff[62:0], xl_ff[63]};
      r_in = r_ff;
      xl_in = xl_ff;
      q_in = q_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (run_ff) begin
         xl_in = {xl_ff[62:0], 1'b0};
         if (carry || (rs >= d_ff)) begin
            r_in = rs - d_ff;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = rs;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (start) begin
         d_in = d;
         if (x_hi >= d) begin
            q_in = '1;
            run_in = 1'b0;
            done_in = 1'b1;
         end else begin
            r_in = x_hi;
            xl_in = x_lo;
            q_in = '0;
            cnt_in = 6'd63;
            run_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      r_ff <= r_in;
      xl_ff <= xl_in;
      q_ff <= q_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign q = q_ff;

endmodule

`default_nettype wire

### sv/tre_dp.sv
`default_nettype none

module tre_dp import tre_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status,
   input  wire logic [31:0]        req_time_us,
   input  wire logic signed [31:0] req_accel_z,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_data,
   output logic signed [31:0]      thrust,
   output logic [30:0]             ratio,
   output logic                    model_updated,
   output logic [7:0]              history_count
);

   localparam int IdxW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FillW = $clog2(HISTORY_DEPTH + 1);
   localparam int SumW  = FillW + 1;

   logic [63:0] mem [0:HISTORY_DEPTH-1];
   logic [63:0] rd_ff;

   logic [19:0] win_low_ff, win_high_ff;
   logic [16:0] forget_ff;
   logic [30:0] init_ratio_ff;

   logic [IdxW-1:0]  head_ff, head_in, head_inc, head_w;
   logic [FillW-1:0] fill_ff, fill_in, fill_w;
   logic [SumW-1:0]  wsum;
   logic [IdxW-1:0]  widx;
   logic [30:0] ratio_ff, ratio_in;
   logic [63:0] cov_ff, cov_in;
   logic [31:0] time_ff;
   logic signed [31:0] acc_ff;
   logic [31:0] thrust_ff, thrust_in;
   logic        upd_ff, upd_in;
   logic [31:0] t_ff, t_in;
   logic        tneg_ff, tneg_in;
   logic [63:0] d_ff, d_in, k_ff, k_in;
   logic [35:0] emag_ff, emag_in;
   logic        eneg_ff, eneg_in;

   logic         mul_start, div_start, mul_done, div_done;
   logic [63:0]  mul_a, mul_b, div_hi, div_lo, div_d, div_q;
   logic [127:0] mul_p;

   logic        acc_neg, full;
   logic [31:0] mag, age, tq;
   logic [63:0] q, rho, delta;
   logic [34:0] tr;
   logic signed [36:0] e;

   always_comb begin
      acc_neg = acc_ff[31];
      mag = acc_neg ? (~acc_ff + 32'd1) : acc_ff;
      age = time_ff - rd_ff[63:32];
      rho = (forget_ff == 17'd0) ? 64'd1 : {47'b0, forget_ff};
      head_inc = (head_ff == IdxW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      full = (fill_ff == FillW'(HISTORY_DEPTH));
      head_w = full ? head_inc : head_ff;
      fill_w = full ? FillW'(HISTORY_DEPTH - 1) : fill_ff;
      wsum = SumW'(head_w) + SumW'(fill_w);
      widx = (wsum >= SumW'(HISTORY_DEPTH)) ? IdxW'(wsum - SumW'(HISTORY_DEPTH))
                                            : IdxW'(wsum);
      tr = mul_p[62:28];
      e = 37'(acc_ff) + (tneg_ff ? 37'(tr) : -37'(tr));
      delta = (mul_p[127:100] != 28'd0) ? '1 : mul_p[99:36];
      // thrust quotient, saturated when the ratio is zero and the magnitude is not
      if (ratio_ff == 31'd0) begin
         q = (mag != 32'd0) ? '1 : '0;
      end else begin
         q = div_q;
      end
      if (acc_neg) begin
         tq = (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
         tq = 32'd0 - tq;
      end else begin
         tq = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
   end

   always_comb begin
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_hi = '0;
      div_lo = '0;
      div_d = d_ff;
      case (cmd.op)
         OP_MUL_TT: begin
            mul_start = 1'b1;
            mul_a = {32'b0, t_ff};
            mul_b = {32'b0, t_ff};
         end
         OP_MUL_TP: begin
            mul_start = 1'b1;
            mul_a = mul_p[63:0];
            mul_b = cov_ff;
         end
         OP_MUL_PT: begin
            mul_start = 1'b1;
            mul_a = cov_ff;
            mul_b = {32'b0, t_ff};
         end
         OP_MUL_TR: begin
            mul_start = 1'b1;
            mul_a = {32'b0, t_ff};
            mul_b = {33'b0, ratio_ff};
         end
         OP_MUL_KE: begin
            mul_start = 1'b1;
            mul_a = k_ff;
            mul_b = {28'b0, emag_ff};
         end
         OP_THR_DIV: begin
            div_start = 1'b1;
            div_lo = {4'b0, mag, 28'b0};
            div_d = {33'b0, ratio_ff};
         end
         OP_DIV_K: begin
            div_start = 1'b1;
            div_hi = mul_p[127:64];
            div_lo = mul_p[63:0];
         end
         OP_DIV_P: begin
            div_start = 1'b1;
            div_hi = {32'b0, cov_ff[63:32]};
            div_lo = {cov_ff[31:0], 32'b0};
         end
         default: begin
         end
      endcase
   end

   tre_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   tre_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x_hi  (div_hi),
      .x_lo  (div_lo),
      .d     (div_d),
      .done  (div_done),
      .q     (div_q)
   );

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      ratio_in = ratio_ff;
      cov_in = cov_ff;
      thrust_in = thrust_ff;
      upd_in = upd_ff;
      t_in = t_ff;
      tneg_in = tneg_ff;
      d_in = d_ff;
      k_in = k_ff;
      emag_in = emag_ff;
      eneg_in = eneg_ff;
      case (cmd.op)
         OP_LATCH: begin
            thrust_in = 32'd0;
            upd_in = 1'b0;
         end
         OP_THR_DONE: begin
            thrust_in = tq;
            head_in = head_w;
            fill_in = fill_w + 1'b1;
         end
         OP_POP: begin
            head_in = head_inc;
            fill_in = fill_ff - 1'b1;
         end
         OP_CONSUME: begin
            head_in = head_inc;
            fill_in = fill_ff - 1'b1;
            upd_in = 1'b1;
            tneg_in = rd_ff[31];
            t_in = rd_ff[31] ? (32'd0 - rd_ff[31:0]) : rd_ff[31:0];
         end
         OP_CAP_D: d_in = mul_p[127:64] + (rho << 16);
         OP_CAP_K: k_in = div_q;
         OP_CAP_E: begin
            eneg_in = e[36];
            emag_in = e[36] ? 36'(-e) : e[35:0];
         end
         OP_CAP_RATIO: begin
            if (tneg_ff != eneg_ff) begin
               ratio_in = (delta >= {33'b0, ratio_ff}) ? 31'd0 : ratio_ff - delta[30:0];
            end else begin
               ratio_in = (delta >= {33'b0, RATIO_MAX - ratio_ff}) ? RATIO_MAX
                                                                   : ratio_ff + delta[30:0];
            end
         end
         OP_CAP_P: cov_in = div_q;
         OP_RESET_MAP: begin
            ratio_in = init_ratio_ff;
            cov_in = COV_INIT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         ratio_ff <= INIT_RATIO_RST;
         cov_ff <= COV_INIT;
         win_low_ff <= WIN_LOW_RST;
         win_high_ff <= WIN_HIGH_RST;
         forget_ff <= FORGET_RST;
         init_ratio_ff <= INIT_RATIO_RST;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         ratio_ff <= ratio_in;
         cov_ff <= cov_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WIN_LOW:    win_low_ff <= csr_data[19:0];
               CSR_WIN_HIGH:   win_high_ff <= csr_data[19:0];
               CSR_FORGET:     forget_ff <= csr_data[16:0];
               CSR_INIT_RATIO: init_ratio_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      thrust_ff <= thrust_in;
      upd_ff <= upd_in;
      t_ff <= t_in;
      tneg_ff <= tneg_in;
      d_ff <= d_in;
      k_ff <= k_in;
      emag_ff <= emag_in;
      eneg_ff <= eneg_in;
      if (cmd.op == OP_LATCH) begin
         time_ff <= req_time_us;
         acc_ff <= req_accel_z;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_THR_DONE) begin
         mem[widx] <= {time_ff, tq};
      end
      rd_ff <= mem[head_ff];
   end

   always_comb begin
      status.mul_done = mul_done;
      status.div_done = div_done;
      status.fill_zero = (fill_ff == '0);
      status.too_old = (age > {12'b0, win_high_ff});
      status.too_young = (age < {12'b0, win_low_ff});
      status.ratio_zero = (ratio_ff == 31'd0);
   end

   assign thrust = thrust_ff;
   assign ratio = ratio_ff;
   assign model_updated = upd_ff;
   assign history_count = 8'(fill_ff);

endmodule

`default_nettype wire

### sv/tre_ctrl.sv
`default_nettype none

module tre_ctrl import tre_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [1:0]    req_type,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd,
   output logic               busy,
   output logic               rsp_valid
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_CMD: state_in = S_THR_DIV;
                  REQ_EST: state_in = S_POP_RD;
                  REQ_RST: state_in = S_RMAP;
                  default: state_in = S_RESULT;
               endcase
            end
         end
         S_THR_DIV:  state_in = status.ratio_zero ? S_THR_DONE : S_THR_W;
         S_THR_W:    if (status.div_done) state_in = S_THR_DONE;
         S_THR_DONE: state_in = S_RESULT;
         S_RMAP:     state_in = S_RESULT;
         S_POP_RD:   state_in = S_POP_CHK;
         S_POP_CHK: begin
            if (status.fill_zero) begin
               state_in = S_RESULT;
            end else if (status.too_old) begin
               state_in = S_POP_RD;
            end else if (status.too_young) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_TT;
            end
         end
         S_TT:     state_in = S_TT_W;
         S_TT_W:   if (status.mul_done) state_in = S_TP;
         S_TP:     state_in = S_TP_W;
         S_TP_W:   if (status.mul_done) state_in = S_PT;
         S_PT:     state_in = S_PT_W;
         S_PT_W:   if (status.mul_done) state_in = S_DK;
         S_DK:     state_in = S_DK_W;
         S_DK_W:   if (status.div_done) state_in = S_TR;
         S_TR:     state_in = S_TR_W;
         S_TR_W:   if (status.mul_done) state_in = S_KE;
         S_KE:     state_in = S_KE_W;
         S_KE_W:   if (status.mul_done) state_in = S_DP;
         S_DP:     state_in = S_DP_W;
         S_DP_W:   if (status.div_done) state_in = S_RESULT;
         S_RESULT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE:     if (start) cmd.op = OP_LATCH;
         S_THR_DIV:  if (!status.ratio_zero) cmd.op = OP_THR_DIV;
         S_THR_DONE: cmd.op = OP_THR_DONE;
         S_RMAP:     cmd.op = OP_RESET_MAP;
         S_POP_CHK: begin
            if (!status.fill_zero) begin
               if (status.too_old) begin
                  cmd.op = OP_POP;
               end else if (!status.too_young) begin
                  cmd.op = OP_CONSUME;
               end
            end
         end
         S_TT:   cmd.op = OP_MUL_TT;
         S_TP:   cmd.op = OP_MUL_TP;
         S_TP_W: if (status.mul_done) cmd.op = OP_CAP_D;
         S_PT:   cmd.op = OP_MUL_PT;
         S_DK:   cmd.op = OP_DIV_K;
         S_DK_W: if (status.div_done) cmd.op = OP_CAP_K;
         S_TR:   cmd.op = OP_MUL_TR;
         S_TR_W: if (status.mul_done) cmd.op = OP_CAP_E;
         S_KE:   cmd.op = OP_MUL_KE;
         S_KE_W: if (status.mul_done) cmd.op = OP_CAP_RATIO;
         S_DP:   cmd.op = OP_DIV_P;
         S_DP_W: if (status.div_done) cmd.op = OP_CAP_P;
         default: cmd.op = OP_NONE;
      endcase
      busy = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not make the block busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block not idle after a response");

endmodule

`default_nettype wire

### sv/thrust_ratio_rls_estimator_top.sv
`default_nettype none

// channel    ports                                         direction
// request    start, busy, req_type, req_time_us,           in (busy out)
//            req_accel_z
// response   rsp_valid, rsp_thrust, rsp_ratio,             out
//            rsp_model_updated, rsp_history_count
// csr        csr_we, csr_index, csr_data                   in
//
// one request at a time; a request is taken when start is high and busy is low
// command request: one thrust division by the ratio in the 64-step serial divider,
//    skipped when the ratio is zero, then the result state
// estimate request: a read and a check of each examined entry, then for an update
//    five multiplies and two divisions in turn, then the result state
// reset mapping: the map reset state, then the result state; unknown requests: the result state only
// synchronous active-high reset; history memory needs no clearing pass
// the response strobe lasts one cycle and cannot be stalled
module thrust_ratio_rls_estimator_top import tre_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic [31:0]        req_time_us,
   input  wire logic signed [31:0] req_accel_z,
   // response
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_thrust,
   output logic [30:0]             rsp_ratio,
   output logic                    rsp_model_updated,
   output logic [7:0]              rsp_history_count,
   // csr write port
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_data
);

   // command and status between sequencer and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   tre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // history memory, ratio/covariance registers and the shared mul/div units
   tre_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_time_us   (req_time_us),
      .req_accel_z   (req_accel_z),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .thrust        (rsp_thrust),
      .ratio         (rsp_ratio),
      .model_updated (rsp_model_updated),
      .history_count (rsp_history_count)
   );

endmodule

`default_nettype wire
